// File: rtl/sms_pkg.sv
// Shared types, constants and sigma functions for the SHA-256 message schedule.
// No dependencies.
package sms_pkg;

  localparam int WordW       = 32;
  localparam int ByteW       = 8;
  localparam int PosW        = 6;   // byte position within a 64-byte block
  localparam int LoadIdxW    = 4;   // index of W0..W15
  localparam int IdxW        = 6;   // index of W0..W63
  localparam int WindowDepth = 16;
  localparam int QueueDepth  = 2;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCntW       = $clog2(QueueDepth + 1);

  localparam logic [IdxW-1:0]     LastIdx     = IdxW'(63);
  localparam logic [IdxW-1:0]     FirstExtIdx = IdxW'(16);
  localparam logic [LoadIdxW-1:0] LastLoadIdx = LoadIdxW'(15);

  // one packed message word on its way from the front to the back
  typedef struct packed {
    logic [WordW-1:0]    word;
    logic [LoadIdxW-1:0] idx;
  } msg_word_t;

  function automatic logic [WordW-1:0] ror32(input logic [WordW-1:0] x, input int n);
    ror32 = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] sigma0(input logic [WordW-1:0] x);
    sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] sigma1(input logic [WordW-1:0] x);
    sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: rtl/sha256_message_schedule.sv
// SHA-256 message schedule expansion: top level joining front end, queue and back end.
// Depends on sms_pkg, sms_front, sms_queue, sms_back.
// Usage: feed the 64 bytes of a message block one item at a time, first byte first. Words
// W0..W15 come out as each fourth byte arrives (through a two-entry queue and then the back
// end's output register), then W16..W63 follow, one per cycle while out_ready is high, from a
// single shared sigma/add unit working on a 16-word shift window; last_word marks W63. Bytes
// are taken one per cycle, but a word's fourth byte waits while the queue is full; while the
// back end extends one block the front keeps taking the next block's bytes until the queue
// and its gather register fill (11 bytes). No clearing after reset.
module sha256_message_schedule import sms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] data_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] word,
  output logic [IdxW-1:0]  word_index,
  output logic             last_word
);

  logic      push_valid;
  logic      push_ready;
  msg_word_t push_data;
  logic      pop_valid;
  logic      pop_ready;
  msg_word_t pop_data;

  sms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word       (word),
    .word_index (word_index),
    .last_word  (last_word)
  );

endmodule

// File: rtl/sms_front.sv
// Front end: takes message bytes and packs each four of them big-endian into a word.
// Depends on sms_pkg.
module sms_front import sms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] data_byte,
  output logic             push_valid,
  input  logic             push_ready,
  output msg_word_t        push_data
);

  logic [PosW-1:0]        pos;
  logic [3*ByteW-1:0]     partial;
  logic                   completes;

  assign completes  = (pos[1:0] == 2'b11);
  // bytes that only gather never wait on the queue
  assign in_ready   = !completes || push_ready;
  assign push_valid = in_valid && completes;
  assign push_data  = '{word: {partial, data_byte}, idx: pos[PosW-1:2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      partial <= '0;
    end else if (in_valid && in_ready) begin
      pos     <= pos + PosW'(1);
      partial <= {partial[2*ByteW-1:0], data_byte};
    end
  end

endmodule

// File: rtl/sms_queue.sv
// Short word queue between the front and back ends.
// Depends on sms_pkg.
module sms_queue import sms_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  msg_word_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output msg_word_t pop_data
);

  msg_word_t        mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != QCntW'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCntW'(1);
      end
    end
  end

endmodule

// File: rtl/sms_back.sv
// Back end: emits W0..W15 from the queue, then extends the schedule to W63.
// Depends on sms_pkg.
module sms_back import sms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  msg_word_t        pop_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] word,
  output logic [IdxW-1:0]  word_index,
  output logic             last_word
);

  typedef enum logic {ST_LOAD, ST_EXTEND} state_t;

  state_t           state;
  logic [IdxW-1:0]  ext_idx;
  // win[0] is W[i-16], win[15] is W[i-1]
  logic [WordW-1:0] win [WindowDepth];
  logic             slot_free;
  logic             do_pop;
  logic             shift_en;
  logic [WordW-1:0] shift_in;
  logic [WordW-1:0] ext_word;

  assign slot_free = !out_valid || out_ready;
  assign pop_ready = (state == ST_LOAD) && slot_free;
  assign do_pop    = pop_valid && pop_ready;
  assign ext_word  = win[0] + sigma0(win[1]) + win[9] + sigma1(win[14]);
  assign shift_en  = do_pop || ((state == ST_EXTEND) && slot_free);
  assign shift_in  = (state == ST_LOAD) ? pop_data.word : ext_word;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 0; k < WindowDepth - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[WindowDepth-1] <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      ext_idx   <= FirstExtIdx;
      out_valid <= 1'b0;
      last_word <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (do_pop) begin
            out_valid  <= 1'b1;
            word       <= pop_data.word;
            word_index <= {2'b00, pop_data.idx};
            last_word  <= 1'b0;
            if (pop_data.idx == LastLoadIdx) begin
              state   <= ST_EXTEND;
              ext_idx <= FirstExtIdx;
            end
          end
        end
        ST_EXTEND: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            word       <= ext_word;
            word_index <= ext_idx;
            last_word  <= (ext_idx == LastIdx);
            if (ext_idx == LastIdx) begin
              state <= ST_LOAD;
            end else begin
              ext_idx <= ext_idx + IdxW'(1);
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

// File: rtl/sms_checker.sv
// Port-level checks for sha256_message_schedule, attached by bind.
// Depends on sms_pkg.
module sms_checker import sms_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [ByteW-1:0] data_byte,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WordW-1:0] word,
  input logic [IdxW-1:0]  word_index,
  input logic             last_word
);

  logic [IdxW-1:0] exp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx <= exp_idx + IdxW'(1);
    end
  end

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(data_byte))
    else $error("waiting input item changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word) && $stable(word_index)
      && $stable(last_word))
    else $error("stalled item changed");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == LastIdx)))
    else $error("last_word does not match index");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_index == exp_idx))
    else $error("word index out of sequence");

endmodule

bind sha256_message_schedule sms_checker u_sms_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .data_byte  (data_byte),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .word       (word),
  .word_index (word_index),
  .last_word  (last_word)
);
